// ===== rtl/krqs_pkg.sv =====
// krqs_pkg: shared constants and types for the keyed record quicksort unit
// no dependencies
package krqs_pkg;

  localparam int MaxRecords = 64;
  localparam int KeyW = 32;
  localparam int PayW = 16;

  typedef struct packed {
    logic signed [KeyW-1:0] sort_key;
    logic signed [PayW-1:0] payload_a;
    logic signed [PayW-1:0] payload_b;
    logic signed [PayW-1:0] payload_c;
    logic signed [PayW-1:0] payload_d;
    logic last_record;
  } in_rec_t;

  typedef struct packed {
    logic signed [KeyW-1:0] sorted_key;
    logic signed [PayW-1:0] out_payload_a;
    logic signed [PayW-1:0] out_payload_b;
    logic signed [PayW-1:0] out_payload_c;
    logic signed [PayW-1:0] out_payload_d;
    logic end_of_run;
    logic overflow_flag;
  } out_rec_t;

  // record as held in the store: key then four payloads
  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [4*PayW-1:0] pay;
  } rec_t;

endpackage

// ===== rtl/krqs_if.sv =====
// krqs_in_if / krqs_out_if: valid-ready channels for records in and out
// depends on krqs_pkg
interface krqs_in_if;
  logic valid;
  logic ready;
  krqs_pkg::in_rec_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface krqs_out_if;
  logic valid;
  logic ready;
  krqs_pkg::out_rec_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/krqs_store.sv =====
// krqs_store: record memory, one write port and one registered read port
// depends on krqs_pkg
module krqs_store #(
  parameter int Depth = krqs_pkg::MaxRecords,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  krqs_pkg::rec_t      wdata,
  input  logic [AW-1:0]       raddr,
  output krqs_pkg::rec_t      rdata
);
  krqs_pkg::rec_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/krqs_stack.sv =====
// krqs_stack: lo/hi range stack memory for the sort sequencer
// depends on nothing
module krqs_stack #(
  parameter int Depth = 64,
  parameter int IW = 7,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  logic [2*IW-1:0] wdata,
  input  logic [AW-1:0]   raddr,
  output logic [2*IW-1:0] rdata
);
  logic [2*IW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/keyed_record_quicksort_unit.sv =====
// keyed_record_quicksort_unit: loads records, quicksorts them by key, streams them out
// depends on krqs_pkg, krqs_if, krqs_store, krqs_stack
// loading takes one record per cycle; each popped range is then partitioned on one store
//   port and one key comparator: fetch the middle pivot, move smaller keys to the front,
//   place the pivot and push the parts still to sort; the empty-stack pop starts the emit pass
// output: each beat sits in one output register and the next is loaded only once it is taken
// input: in.ready low from the last record of a set until its last sorted beat is taken
// reset: synchronous rst clears sequencer, count, stack pointer and drop flag; stores keep data
module keyed_record_quicksort_unit #(
  parameter int MAX_RECORDS = krqs_pkg::MaxRecords
) (
  input logic clk,
  input logic rst,
  krqs_in_if.sink in,
  krqs_out_if.source out
);
  localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int IW = $clog2(MAX_RECORDS + 1);
  localparam int SW = AW + 1;

  // one-hot sequencer states
  typedef enum logic [16:0] {
    S_LOAD  = 17'h00001,
    S_POP   = 17'h00002,
    S_RNG   = 17'h00004,
    S_MRD   = 17'h00008,
    S_MWT   = 17'h00010,
    S_MSW   = 17'h00020,
    S_JRD   = 17'h00040,
    S_JCHK  = 17'h00080,
    S_ISW   = 17'h00100,
    S_JSW   = 17'h00200,
    S_FIN   = 17'h00400,
    S_FHI   = 17'h00800,
    S_FPV   = 17'h01000,
    S_PUSH  = 17'h02000,
    S_EMIT  = 17'h04000,
    S_ELD   = 17'h08000,
    S_EOUT  = 17'h10000
  } state_t;

  state_t state;
  logic [IW-1:0] count;
  logic dropped;
  logic [IW-1:0] lo, hi, i, j;
  logic signed [krqs_pkg::KeyW-1:0] pv;
  krqs_pkg::rec_t ra;          // pivot record, kept out of the store during the scan
  krqs_pkg::rec_t rb;          // record at j held for a swap
  logic [SW-1:0] sp;
  logic push_step;

  // store port
  logic st_we;
  logic [AW-1:0] st_wa, st_ra;
  krqs_pkg::rec_t st_wd, st_rd;

  // stack port
  logic sk_we;
  logic [AW-1:0] sk_wa, sk_ra;
  logic [2*IW-1:0] sk_wd, sk_rd;

  // emit side: read index and one output register
  logic [IW-1:0] rd_idx;
  logic ovalid;
  krqs_pkg::out_rec_t odata;

  logic in_fire;
  logic has_room;
  logic [IW-1:0] n_new;
  logic sp_room;
  logic [IW:0] mid_sum;
  logic [AW-1:0] hi_m1;

  krqs_store #(.Depth(MAX_RECORDS)) u_store (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd),
    .raddr(st_ra), .rdata(st_rd)
  );

  krqs_stack #(.Depth(MAX_RECORDS), .IW(IW)) u_stack (
    .clk(clk), .we(sk_we), .waddr(sk_wa), .wdata(sk_wd),
    .raddr(sk_ra), .rdata(sk_rd)
  );

  assign in.ready = (state == S_LOAD);
  assign out.valid = ovalid;
  assign out.data = odata;

  assign in_fire = in.valid && in.ready;
  assign has_room = (count < IW'(MAX_RECORDS));
  // records held once this beat is taken; a beat on a full store is dropped
  assign n_new = has_room ? count + IW'(1) : count;
  assign sp_room = (sp < SW'(MAX_RECORDS));

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign hi_m1 = hi[AW-1:0] - AW'(1);

  // combinational port drive; store reads land in the cycle after the address
  always_comb begin
    st_we = 1'b0;
    st_wa = i[AW-1:0];
    st_wd = ra;
    st_ra = j[AW-1:0];
    sk_we = 1'b0;
    sk_wa = sp[AW-1:0];
    sk_wd = {lo, hi};
    sk_ra = sp[AW-1:0] - AW'(1);
    case (state)
      S_LOAD: begin
        st_we = in_fire && has_room;
        st_wa = count[AW-1:0];
        st_wd = {in.data.sort_key, in.data.payload_d, in.data.payload_c,
                 in.data.payload_b, in.data.payload_a};
        // whole set is the first range
        if (in_fire && in.data.last_record && n_new >= IW'(2)) begin
          sk_we = 1'b1;
          sk_wa = '0;
          sk_wd = {IW'(0), n_new};
        end
      end
      S_MRD: st_ra = mid_sum[AW:1];
      S_MWT: st_ra = hi_m1;
      S_MSW: begin
        // record at hi-1 moves to mid; the pivot stays in ra
        st_we = 1'b1;
        st_wa = mid_sum[AW:1];
        st_wd = st_rd;
      end
      S_JCHK: st_ra = i[AW-1:0];
      S_ISW: begin
        st_we = 1'b1;
        st_wa = j[AW-1:0];
        st_wd = st_rd;
      end
      S_JSW: begin
        st_we = 1'b1;
        st_wa = i[AW-1:0];
        st_wd = rb;
      end
      S_FIN: st_ra = i[AW-1:0];
      S_FHI: begin
        // record at the boundary goes to hi-1
        st_we = 1'b1;
        st_wa = hi_m1;
        st_wd = st_rd;
      end
      S_FPV: begin
        // pivot lands on the boundary, last write wins when i is hi-1
        st_we = 1'b1;
        st_wa = i[AW-1:0];
        st_wd = ra;
      end
      S_PUSH: begin
        // right part first so the left part is popped first
        if (!push_step) begin
          sk_we = (hi >= i + IW'(3)) && sp_room;
          sk_wd = {i + IW'(1), hi};
        end else begin
          sk_we = (i >= lo + IW'(2)) && sp_room;
          sk_wd = {lo, i};
        end
      end
      S_EMIT: st_ra = rd_idx[AW-1:0];
      S_EOUT: st_ra = rd_idx[AW-1:0] + AW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      dropped <= 1'b0;
      sp <= '0;
      ovalid <= 1'b0;
      push_step <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (has_room) count <= count + IW'(1);
            else dropped <= 1'b1;
            if (in.data.last_record) begin
              rd_idx <= '0;
              if (n_new >= IW'(2)) begin
                sp <= SW'(1);
                state <= S_POP;
              end else begin
                state <= S_EMIT;
              end
            end
          end
        end
        S_POP: begin
          if (sp == '0) begin
            rd_idx <= '0;
            state <= S_EMIT;
          end else begin
            sp <= sp - SW'(1);
            state <= S_RNG;
          end
        end
        S_RNG: begin
          lo <= sk_rd[2*IW-1:IW];
          hi <= sk_rd[IW-1:0];
          state <= S_MRD;
        end
        S_MRD: state <= S_MWT;
        S_MWT: begin
          ra <= st_rd;
          pv <= st_rd.key;
          state <= S_MSW;
        end
        S_MSW: begin
          i <= lo;
          j <= lo;
          state <= S_JRD;
        end
        S_JRD: begin
          if (j >= hi - IW'(1)) state <= S_FIN;
          else state <= S_JCHK;
        end
        S_JCHK: begin
          // strictly less moves to the front
          if ($signed(st_rd.key) < pv) begin
            rb <= st_rd;
            state <= S_ISW;
          end else begin
            j <= j + IW'(1);
            state <= S_JRD;
          end
        end
        S_ISW: state <= S_JSW;
        S_JSW: begin
          i <= i + IW'(1);
          j <= j + IW'(1);
          state <= S_JRD;
        end
        S_FIN: state <= S_FHI;
        S_FHI: state <= S_FPV;
        S_FPV: state <= S_PUSH;
        S_PUSH: begin
          if (sk_we) sp <= sp + SW'(1);
          if (!push_step) begin
            push_step <= 1'b1;
          end else begin
            push_step <= 1'b0;
            state <= S_POP;
          end
        end
        S_EMIT: state <= S_ELD;
        S_ELD: begin
          odata.sorted_key <= st_rd.key;
          odata.out_payload_a <= st_rd.pay[krqs_pkg::PayW-1:0];
          odata.out_payload_b <= st_rd.pay[2*krqs_pkg::PayW-1:krqs_pkg::PayW];
          odata.out_payload_c <= st_rd.pay[3*krqs_pkg::PayW-1:2*krqs_pkg::PayW];
          odata.out_payload_d <= st_rd.pay[4*krqs_pkg::PayW-1:3*krqs_pkg::PayW];
          odata.end_of_run <= (rd_idx == count - IW'(1));
          odata.overflow_flag <= dropped;
          ovalid <= 1'b1;
          state <= S_EOUT;
        end
        S_EOUT: begin
          // next record is already addressed while this beat waits
          if (out.ready) begin
            ovalid <= 1'b0;
            if (rd_idx == count - IW'(1)) begin
              count <= '0;
              dropped <= 1'b0;
              state <= S_LOAD;
            end else begin
              rd_idx <= rd_idx + IW'(1);
              state <= S_ELD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // output beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(out.data));
  // input and output never open together
  a_in_out_excl: assert property (@(posedge clk) disable iff (rst)
    !(in.ready && out.valid));
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= IW'(MAX_RECORDS));
  a_sp_cap: assert property (@(posedge clk) disable iff (rst)
    sp <= SW'(MAX_RECORDS));
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state));
endmodule
